FILE: hdl/lcs_length_and_traceback_assert.svh
// ---------------------------------------------------------------------------
// lcs_length_and_traceback_assert
// Assertion macros used by the LCS engine controller.
// ---------------------------------------------------------------------------
`ifndef LCS_LENGTH_AND_TRACEBACK_ASSERT_SVH
`define LCS_LENGTH_AND_TRACEBACK_ASSERT_SVH

// Clocked implication assertion with active-low reset disable.
`define LCS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication assertion.
`define LCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lcs_pkg.sv
// ---------------------------------------------------------------------------
// lcs_pkg
// Shared types and codes for the LCS engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcs_pkg;

    localparam logic [1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_A,
        OP_LOAD_B,
        OP_FILL_START,
        OP_FILL_READ,
        OP_FILL_WRITE,
        OP_TB_START,
        OP_TB_READ,
        OP_TB_DECIDE,
        OP_EMIT_START,
        OP_EMIT_READ,
        OP_EMIT_SHOW
    } lcs_op_t;

    typedef struct packed {
        logic fill_done;   // last cell written
        logic tb_done;     // traceback finished
        logic emit_last;   // current emit index is the last
        logic len_zero;    // subsequence empty
    } lcs_status_t;

endpackage

FILE: hdl/lcs_ram.sv
// ---------------------------------------------------------------------------
// lcs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/lcs_datapath.sv
// ---------------------------------------------------------------------------
// lcs_datapath
// String buffers, score table, traceback pointers and result buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcs_datapath #(
    parameter int MAX_LEN = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcs_pkg::lcs_op_t    op,
    input  logic [7:0]          char_in,
    output lcs_pkg::lcs_status_t status,
    output logic [5:0]          lcs_length,
    output logic [7:0]          lcs_char,
    output logic                overflow
);

    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DIM  = MAX_LEN + 1;
    localparam int TD   = DIM * DIM;
    localparam int TW   = $clog2(TD);
    localparam int VW   = CW;

    logic [CW-1:0] cnt_a_reg, cnt_b_reg;
    logic          ovf_reg;
    logic [CW-1:0] row_reg, col_reg;       // fill or traceback position
    logic [CW-1:0] pos_reg;                // traceback write index / emit index
    logic [VW-1:0] len_reg;
    logic [VW-1:0] left_reg;               // value of cell (row, col-1) during fill
    logic [TW-1:0] addr_reg;               // row*DIM+col, tracked incrementally

    // string and table ports
    logic [AW-1:0] sa_raddr, sb_raddr, rb_addr_r, rb_waddr;
    logic [7:0]    sa_q, sb_q, rb_q;
    logic          t_we, rb_we;
    logic [TW-1:0] t_waddr, t_raddr1, t_raddr2;
    logic [VW-1:0] t_wdata, t_q1, t_q2;

    lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str_a (
        .aclk(aclk), .we(op == lcs_pkg::OP_LOAD_A && cnt_a_reg < CW'(MAX_LEN)),
        .waddr(cnt_a_reg[AW-1:0]), .wdata(char_in), .raddr(sa_raddr), .rdata(sa_q));
    lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str_b (
        .aclk(aclk), .we(op == lcs_pkg::OP_LOAD_B && cnt_b_reg < CW'(MAX_LEN)),
        .waddr(cnt_b_reg[AW-1:0]), .wdata(char_in), .raddr(sb_raddr), .rdata(sb_q));
    // Two table copies give two read ports (diagonal and up).
    lcs_ram #(.WIDTH(VW), .DEPTH(TD)) u_tbl_0 (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr1), .rdata(t_q1));
    lcs_ram #(.WIDTH(VW), .DEPTH(TD)) u_tbl_1 (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr2), .rdata(t_q2));
    lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_res (
        .aclk(aclk), .we(rb_we), .waddr(rb_waddr), .wdata(sa_q),
        .raddr(rb_addr_r), .rdata(rb_q));

    logic [CW-1:0] rm1, cm1;
    logic          edge0, match;
    logic [VW-1:0] fill_val, up_v, diag_v;

    always_comb begin
        rm1      = row_reg - CW'(1);
        cm1      = col_reg - CW'(1);
        sa_raddr = rm1[AW-1:0];
        sb_raddr = cm1[AW-1:0];
        // fill reads diag at port 1, up at port 2; traceback reads up and left
        if (op == lcs_pkg::OP_TB_READ) begin
            t_raddr1 = addr_reg - TW'(DIM);
            t_raddr2 = addr_reg - TW'(1);
        end else begin
            t_raddr1 = addr_reg - TW'(DIM) - TW'(1);
            t_raddr2 = addr_reg - TW'(DIM);
        end
        edge0    = (row_reg == '0) || (col_reg == '0);
        match    = (sa_q == sb_q);
        diag_v   = t_q1;
        up_v     = t_q2;
        if (edge0) begin
            fill_val = '0;
        end else if (match) begin
            fill_val = diag_v + VW'(1);
        end else begin
            fill_val = (up_v > left_reg) ? up_v : left_reg;
        end
        t_we     = (op == lcs_pkg::OP_FILL_WRITE);
        t_waddr  = addr_reg;
        t_wdata  = fill_val;
        rb_we    = (op == lcs_pkg::OP_TB_DECIDE) && !edge0 && match && (pos_reg != '0);
        rb_waddr = pos_reg[AW-1:0] - AW'(1);
        rb_addr_r = pos_reg[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            case (op)
                lcs_pkg::OP_LOAD_A: begin
                    if (cnt_a_reg < CW'(MAX_LEN)) cnt_a_reg <= cnt_a_reg + CW'(1);
                    else ovf_reg <= 1'b1;
                end
                lcs_pkg::OP_LOAD_B: begin
                    if (cnt_b_reg < CW'(MAX_LEN)) cnt_b_reg <= cnt_b_reg + CW'(1);
                    else ovf_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            lcs_pkg::OP_FILL_START: begin
                row_reg  <= '0;
                col_reg  <= '0;
                addr_reg <= '0;
                left_reg <= '0;
            end
            lcs_pkg::OP_FILL_WRITE: begin
                if (col_reg == cnt_b_reg) begin
                    col_reg  <= '0;
                    row_reg  <= row_reg + CW'(1);
                    addr_reg <= addr_reg + TW'(DIM) - TW'(col_reg);
                    left_reg <= '0;
                end else begin
                    col_reg  <= col_reg + CW'(1);
                    addr_reg <= addr_reg + TW'(1);
                    left_reg <= fill_val;
                end
                if (row_reg == cnt_a_reg && col_reg == cnt_b_reg) begin
                    len_reg <= fill_val;
                    pos_reg <= fill_val;
                end
            end
            lcs_pkg::OP_TB_START: begin
                row_reg  <= cnt_a_reg;
                col_reg  <= cnt_b_reg;
                addr_reg <= TW'(cnt_a_reg) * TW'(DIM) + TW'(cnt_b_reg);
            end
            lcs_pkg::OP_TB_DECIDE: begin
                if (match) begin
                    pos_reg  <= pos_reg - CW'(1);
                    row_reg  <= rm1;
                    col_reg  <= cm1;
                    addr_reg <= addr_reg - TW'(DIM) - TW'(1);
                end else if (t_q1 > t_q2) begin
                    row_reg  <= rm1;
                    addr_reg <= addr_reg - TW'(DIM);
                end else begin
                    col_reg  <= cm1;
                    addr_reg <= addr_reg - TW'(1);
                end
            end
            lcs_pkg::OP_EMIT_START: pos_reg <= '0;
            lcs_pkg::OP_EMIT_SHOW:  pos_reg <= pos_reg + CW'(1);
            default: ;
        endcase
    end

    always_comb begin
        status.fill_done = (row_reg == cnt_a_reg) && (col_reg == cnt_b_reg);
        status.tb_done   = edge0 || (pos_reg == '0);
        status.emit_last = (pos_reg + CW'(1) == len_reg);
        status.len_zero  = (len_reg == '0);
        lcs_length       = (len_reg > VW'(63)) ? 6'd63 : 6'(len_reg);
        lcs_char         = status.len_zero ? 8'd0 : rb_q;
        overflow         = ovf_reg;
    end

endmodule

FILE: hdl/lcs_ctrl.sv
// ---------------------------------------------------------------------------
// lcs_ctrl
// Sequencer for load, table fill, traceback and emit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lcs_length_and_traceback_assert.svh"

module lcs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_char_valid,
    output logic                 m_last_char,
    input  lcs_pkg::lcs_status_t status,
    output lcs_pkg::lcs_op_t     op
);

    typedef enum logic [3:0] {
        S_IDLE, S_FILL_RD, S_FILL_WR, S_TB_SETUP, S_TB_RD, S_TB_DEC,
        S_EMIT_RD, S_EMIT_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic   cv_reg, last_reg;
    logic   acc;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_OUT);
    assign m_char_valid = cv_reg;
    assign m_last_char  = last_reg;
    assign acc          = s_valid && s_ready;

    always_comb begin
        op = lcs_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    case (s_action)
                        lcs_pkg::ACT_LOAD_A:  op = lcs_pkg::OP_LOAD_A;
                        lcs_pkg::ACT_LOAD_B:  op = lcs_pkg::OP_LOAD_B;
                        lcs_pkg::ACT_COMPUTE: op = lcs_pkg::OP_FILL_START;
                        default:              op = lcs_pkg::OP_NONE;
                    endcase
                end
            end
            S_FILL_RD:   op = lcs_pkg::OP_FILL_READ;
            S_FILL_WR:   op = lcs_pkg::OP_FILL_WRITE;
            S_TB_SETUP:  op = lcs_pkg::OP_TB_START;
            S_TB_RD:     op = lcs_pkg::OP_TB_READ;
            S_TB_DEC:    op = status.tb_done ? lcs_pkg::OP_EMIT_START : lcs_pkg::OP_TB_DECIDE;
            S_EMIT_RD:   op = lcs_pkg::OP_EMIT_READ;
            S_OUT:       op = (m_ready && !last_reg) ? lcs_pkg::OP_EMIT_SHOW : lcs_pkg::OP_NONE;
            default:     op = lcs_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE:    if (acc && s_action == lcs_pkg::ACT_COMPUTE) state_reg <= S_FILL_RD;
                S_FILL_RD: state_reg <= S_FILL_WR;
                S_FILL_WR: state_reg <= status.fill_done ? S_TB_SETUP : S_FILL_RD;
                S_TB_SETUP: state_reg <= S_TB_RD;
                S_TB_RD:   state_reg <= S_TB_DEC;
                S_TB_DEC:  state_reg <= status.tb_done ? S_EMIT_RD : S_TB_RD;
                S_EMIT_RD: state_reg <= S_EMIT_WAIT;
                S_EMIT_WAIT: begin
                    cv_reg    <= !status.len_zero;
                    last_reg  <= status.len_zero || status.emit_last;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_ready) state_reg <= last_reg ? S_IDLE : S_EMIT_RD;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `LCS_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready, "accept while busy")
    `LCS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_last_char), "result dropped")
    `LCS_ASSERT_IMPL(a_empty_last, aclk, aresetn, m_valid && !m_char_valid, m_last_char, "empty result not last")

endmodule

FILE: hdl/lcs_length_and_traceback.sv
// ---------------------------------------------------------------------------
// lcs_length_and_traceback
// LCS engine: loads two strings, fills the score table, traces back and
// emits the common subsequence in forward order.
// ---------------------------------------------------------------------------
// Channel | Direction | Payload
// s_      | in        | s_action, s_char_value
// m_      | out       | m_lcs_length, m_lcs_char, m_char_valid, m_last_char, m_overflow
//
// Load requests are taken while idle. A compute request fills the table
// with a read step for the registered table and string reads, then a write
// step, per cell; then a setup step and a read and a decide step per
// traceback step; then a read, a wait and an output step per emitted result.
// No request is taken during compute.
// Reset (aresetn low, synchronous) clears string counts and the overflow flag.
// A stalled result holds until m_ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcs_length_and_traceback #(
    parameter int MAX_LEN = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_char_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_lcs_length,
    output logic [7:0] m_lcs_char,
    output logic       m_char_valid,
    output logic       m_last_char,
    output logic       m_overflow
);

    lcs_pkg::lcs_op_t     op;
    lcs_pkg::lcs_status_t status;

    // Controller: sequences the datapath through each request.
    lcs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_char_valid(m_char_valid), .m_last_char(m_last_char),
        .status(status), .op(op));

    // Datapath: buffers, score table and traceback.
    lcs_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .op(op), .char_in(s_char_value),
        .status(status), .lcs_length(m_lcs_length), .lcs_char(m_lcs_char),
        .overflow(m_overflow));

endmodule

FILE: dv/lcs_length_and_traceback_tb.sv
// ---------------------------------------------------------------------------
// lcs_length_and_traceback_tb
// Drives load and compute requests into the LCS engine with random gaps and
// result back-pressure, predicts every emitted subsequence character and
// compares each result field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class lcs_scoreboard;
    localparam int MAX_LEN = 32;

    // Predicted state of the engine.
    logic [7:0] str_a [MAX_LEN];
    logic [7:0] str_b [MAX_LEN];
    int         len_a;
    int         len_b;
    bit         ovf_seen;

    // Results predicted but not yet seen, oldest first.
    logic [16:0] pending_results [$];
    int          mismatches;

    function void clear();
        len_a = 0;
        len_b = 0;
        ovf_seen = 0;
        mismatches = 0;
        pending_results.delete();
    endfunction

    // Note one accepted request and predict the results it causes.
    function void note_request(logic [1:0] act, logic [7:0] ch);
        int         score [MAX_LEN+1][MAX_LEN+1];
        logic [7:0] subseq [MAX_LEN];
        int         r;
        int         c;
        int         pos;
        int         total;
        if (act == lcs_pkg::ACT_LOAD_A) begin
            if (len_a < MAX_LEN) begin
                str_a[len_a] = ch;
                len_a++;
            end else begin
                ovf_seen = 1;
            end
        end else if (act == lcs_pkg::ACT_LOAD_B) begin
            if (len_b < MAX_LEN) begin
                str_b[len_b] = ch;
                len_b++;
            end else begin
                ovf_seen = 1;
            end
        end else if (act == lcs_pkg::ACT_COMPUTE) begin
            for (r = 0; r <= len_a; r++) begin
                for (c = 0; c <= len_b; c++) begin
                    if (r == 0 || c == 0) begin
                        score[r][c] = 0;
                    end else if (str_a[r-1] == str_b[c-1]) begin
                        score[r][c] = score[r-1][c-1] + 1;
                    end else begin
                        score[r][c] = (score[r-1][c] > score[r][c-1]) ?
                                      score[r-1][c] : score[r][c-1];
                    end
                end
            end
            total = score[len_a][len_b];
            pos = total;
            r = len_a;
            c = len_b;
            // Walk back from the corner; a tie steps left.
            while (r > 0 && c > 0 && pos > 0) begin
                if (str_a[r-1] == str_b[c-1]) begin
                    pos--;
                    subseq[pos] = str_a[r-1];
                    r--;
                    c--;
                end else if (score[r-1][c] > score[r][c-1]) begin
                    r--;
                end else begin
                    c--;
                end
            end
            if (total == 0) begin
                pending_results.push_back({6'd0, 8'd0, 1'b0, 1'b1, ovf_seen});
            end else begin
                for (int k = 0; k < total; k++) begin
                    pending_results.push_back({6'(total), subseq[k], 1'b1,
                                               1'(k == total - 1), ovf_seen});
                end
            end
        end
    endfunction

    function void check_result(logic [5:0] length, logic [7:0] ch, logic cv,
                               logic last, logic ovf);
        logic [16:0] exp;
        if (pending_results.size() == 0) begin
            $error("unexpected result: length %0d char %0h", length, ch);
            mismatches++;
            return;
        end
        exp = pending_results.pop_front();
        if (length !== exp[16:11]) begin
            $error("lcs_length expected %0d actual %0d", exp[16:11], length);
            mismatches++;
        end
        if (ch !== exp[10:3]) begin
            $error("lcs_char expected %0h actual %0h", exp[10:3], ch);
            mismatches++;
        end
        if (cv !== exp[2]) begin
            $error("char_valid expected %0b actual %0b", exp[2], cv);
            mismatches++;
        end
        if (last !== exp[1]) begin
            $error("last_char expected %0b actual %0b", exp[1], last);
            mismatches++;
        end
        if (ovf !== exp[0]) begin
            $error("overflow expected %0b actual %0b", exp[0], ovf);
            mismatches++;
        end
    endfunction
endclass

module lcs_length_and_traceback_tb;

    localparam int CYCLE_LIMIT = 2000000;
    // Action code with no meaning; the engine must drop it.
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_action;
    logic [7:0] s_char_value;
    logic       m_valid;
    logic       m_ready;
    logic [5:0] m_lcs_length;
    logic [7:0] m_lcs_char;
    logic       m_char_valid;
    logic       m_last_char;
    logic       m_overflow;

    lcs_scoreboard lcs_board;
    int            cycle_count;
    int            m_hold;
    bit            stall_enable;

    lcs_length_and_traceback #(.MAX_LEN(32)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_char_value (s_char_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_lcs_length (m_lcs_length),
        .m_lcs_char   (m_lcs_char),
        .m_char_valid (m_char_valid),
        .m_last_char  (m_last_char),
        .m_overflow   (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // Send one request: hold valid and payload until the engine takes it.
    // Valid drops only for a gap, so back-to-back requests keep it high.
    task automatic send_request(logic [1:0] act, logic [7:0] ch);
        int gap;
        gap = stall_enable ? gap_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_char_value <= ch;
        do @(posedge aclk); while (!(s_valid && s_ready));
        lcs_board.note_request(act, ch);
    endtask

    // Load a string pair of chosen lengths from a small alphabet, then compute.
    task automatic run_pair(int la, int lb, int alphabet);
        for (int i = 0; i < la; i++)
            send_request(lcs_pkg::ACT_LOAD_A,
                         8'($urandom_range(0, alphabet - 1) + 8'h61));
        for (int i = 0; i < lb; i++)
            send_request(lcs_pkg::ACT_LOAD_B,
                         8'($urandom_range(0, alphabet - 1) + 8'h61));
        send_request(lcs_pkg::ACT_COMPUTE, 8'($urandom));
    endtask

    // Result side: random back-pressure with rare long holds, check on every
    // handshake.
    initial begin
        m_ready = 1'b0;
        m_hold  = 0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                lcs_board.check_result(m_lcs_length, m_lcs_char, m_char_valid,
                                       m_last_char, m_overflow);
            if (!stall_enable) begin
                m_ready <= 1'b1;
            end else if (m_hold > 0) begin
                m_hold--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                m_hold = $urandom_range(10, 40);
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= $urandom_range(0, 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("lcs_length_and_traceback test failed");
                $finish;
            end
        end
    end

    initial begin
        lcs_board = new();
        lcs_board.clear();
        stall_enable = 0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_action     <= lcs_pkg::ACT_LOAD_A;
        s_char_value <= 8'h00;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: compute on empty strings, extremes, ignored action,
        // no common character, a tie-heavy pair.
        send_request(lcs_pkg::ACT_COMPUTE, 8'hFF);
        send_request(lcs_pkg::ACT_LOAD_A, 8'h00);
        send_request(lcs_pkg::ACT_COMPUTE, 8'h00);
        send_request(ACT_UNKNOWN, 8'hFF);
        send_request(lcs_pkg::ACT_LOAD_B, 8'hFF);
        send_request(lcs_pkg::ACT_COMPUTE, 8'hAA);
        send_request(lcs_pkg::ACT_LOAD_A, 8'hFF);
        send_request(lcs_pkg::ACT_LOAD_B, 8'h00);
        send_request(lcs_pkg::ACT_COMPUTE, 8'h55);
        send_request(lcs_pkg::ACT_LOAD_A, 8'h5A);
        send_request(lcs_pkg::ACT_LOAD_B, 8'hA5);
        send_request(lcs_pkg::ACT_LOAD_B, 8'h5A);
        send_request(ACT_UNKNOWN, 8'h00);
        send_request(lcs_pkg::ACT_COMPUTE, 8'h00);

        // Random: strings grow across computes, since nothing clears them; overflow
        // appears only once both buffers are filled near the end.
        stall_enable = 1;
        for (int p = 0; p < 10; p++) begin
            if ($urandom_range(0, 9) == 0) send_request(ACT_UNKNOWN, 8'($urandom));
            run_pair($urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(1, 4));
        end
        // Fill both buffers to capacity (A from 00, 01, FE and FF, B full-range), then overflow.
        while (lcs_board.len_a < 32)
            send_request(lcs_pkg::ACT_LOAD_A,
                         ($urandom_range(0, 1) ? 8'h00 : 8'hFF) ^
                         8'($urandom_range(0, 1)));
        while (lcs_board.len_b < 32)
            send_request(lcs_pkg::ACT_LOAD_B, 8'($urandom));
        send_request(lcs_pkg::ACT_COMPUTE, 8'h00);
        send_request(lcs_pkg::ACT_LOAD_A, 8'h77);
        send_request(lcs_pkg::ACT_LOAD_B, 8'h88);
        send_request(lcs_pkg::ACT_COMPUTE, 8'hFF);
        stall_enable = 0;
        send_request(lcs_pkg::ACT_COMPUTE, 8'h00);
        stall_enable = 1;
        for (int p = 0; p < 4; p++) send_request(lcs_pkg::ACT_COMPUTE, 8'($urandom));
        s_valid <= 1'b0;

        // Drain, then allow a short tail for any stray result.
        while (lcs_board.pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (lcs_board.mismatches == 0 && lcs_board.pending_results.size() == 0)
            $display("lcs_length_and_traceback test passed");
        else
            $display("lcs_length_and_traceback test failed");
        $finish;
    end
endmodule
